### rtl/core/dbtc_pkg.sv
// Shared types, constants and color stop tables for the dB to thermal color mapper.
`timescale 1ns / 1ps

package dbtc_pkg;

    // Field and datapath widths
    localparam int DB_W      = 16;            // signed dB value, Q8.8
    localparam int Q_W       = 16;            // quotient bits of the normalized level
    localparam int T_W       = Q_W + 1;       // normalized level 0..65536
    localparam int CH_W      = 8;             // one color channel
    localparam int NCH       = 3;             // red, green, blue
    localparam int D_W       = 14;            // offset inside a segment, at most 13107
    localparam int NUM_W     = D_W + CH_W;    // blend numerator, at most 255 * 13107
    localparam int NSTOP     = 7;
    localparam int NSEG      = NSTOP - 1;
    localparam int SEG_W     = 3;
    localparam int CFG_IDX_W = 2;

    // Quotient bits resolved per pipeline stage
    localparam int DIV_STEP      = 2;
    localparam int T_DIV_STAGES  = Q_W / DIV_STEP;
    localparam int C_DIV_STAGES  = CH_W / DIV_STEP;

    localparam logic [T_W-1:0] T_ONE = T_W'(1) << Q_W;

    // Channel positions inside a color word
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_DB = 2'd0,
        REG_MAX_DB = 2'd1
    } t_cfg_reg;

    localparam logic signed [DB_W-1:0] MIN_DB_RST = 16'sh9C00;  // -100 dB
    localparam logic signed [DB_W-1:0] MAX_DB_RST = 16'sh0000;

    typedef logic [NCH-1:0][CH_W-1:0] t_rgb;

    // Normalization divider lane
    typedef struct packed {
        logic           zero;   // level clamps to the floor
        logic           one;    // level clamps to the ceiling
        logic [Q_W-1:0] rem;
        logic [Q_W-1:0] div;
        logic [Q_W-1:0] q;
    } t_tdiv;

    // Segment index and offset inside it
    typedef struct packed {
        logic [SEG_W-1:0] seg;
        logic [D_W-1:0]   d;
    } t_segd;

    // Blend numerators and the segment length they divide by
    typedef struct packed {
        logic [NCH-1:0][NUM_W-1:0] num;
        logic [D_W-1:0]            len;
    } t_blend;

    // Color divider lane
    typedef struct packed {
        logic [NCH-1:0][NUM_W-1:0] rem;
        logic [D_W-1:0]            len;
        t_rgb                      q;
    } t_cdiv;

    // Stop positions on the 0..65536 scale
    function automatic logic [T_W-1:0] stop_pos(input logic [SEG_W-1:0] idx);
        logic [T_W-1:0] p;
        case (idx)
            3'd0:    p = T_W'(0);
            3'd1:    p = T_W'(9830);
            3'd2:    p = T_W'(19661);
            3'd3:    p = T_W'(32768);
            3'd4:    p = T_W'(42598);
            3'd5:    p = T_W'(52429);
            default: p = T_ONE;
        endcase
        return p;
    endfunction

    // Stop colors: black, blue, cyan, green, yellow, red, white
    function automatic t_rgb stop_rgb(input logic [SEG_W-1:0] idx);
        t_rgb c;
        c = '0;
        case (idx)
            3'd0: begin
                c[CH_RED] = 8'd0;   c[CH_GREEN] = 8'd0;   c[CH_BLUE] = 8'd20;
            end
            3'd1: begin
                c[CH_RED] = 8'd0;   c[CH_GREEN] = 8'd0;   c[CH_BLUE] = 8'd160;
            end
            3'd2: begin
                c[CH_RED] = 8'd0;   c[CH_GREEN] = 8'd180; c[CH_BLUE] = 8'd220;
            end
            3'd3: begin
                c[CH_RED] = 8'd0;   c[CH_GREEN] = 8'd220; c[CH_BLUE] = 8'd80;
            end
            3'd4: begin
                c[CH_RED] = 8'd220; c[CH_GREEN] = 8'd220; c[CH_BLUE] = 8'd0;
            end
            3'd5: begin
                c[CH_RED] = 8'd255; c[CH_GREEN] = 8'd80;  c[CH_BLUE] = 8'd0;
            end
            default: begin
                c[CH_RED] = 8'd255; c[CH_GREEN] = 8'd255; c[CH_BLUE] = 8'd255;
            end
        endcase
        return c;
    endfunction

    // Length of a segment between two neighboring stops
    function automatic logic [D_W-1:0] seg_len(input logic [SEG_W-1:0] seg);
        logic [T_W-1:0] diff;
        diff = stop_pos(seg + SEG_W'(1)) - stop_pos(seg);
        return diff[D_W-1:0];
    endfunction

endpackage

### rtl/core/dbtc_ifs.sv
// Stream and configuration interfaces of the dB to thermal color mapper.
`timescale 1ns / 1ps

interface dbtc_pix_if;
    logic                             valid;
    logic                             ready;
    logic signed [dbtc_pkg::DB_W-1:0] magnitude_db;
    modport source (output valid, output magnitude_db, input ready);
    modport sink   (input valid, input magnitude_db, output ready);
endinterface

interface dbtc_color_if;
    logic                      valid;
    logic                      ready;
    logic [dbtc_pkg::CH_W-1:0] red;
    logic [dbtc_pkg::CH_W-1:0] green;
    logic [dbtc_pkg::CH_W-1:0] blue;
    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface dbtc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dbtc_pkg::CFG_IDX_W-1:0] index;
    logic [dbtc_pkg::DB_W-1:0]      data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/dbtc_norm.sv
// Normalization pipeline: offset and span, clamp, then a radix-4 restoring divider.
`timescale 1ns / 1ps

module dbtc_norm (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic signed [dbtc_pkg::DB_W-1:0] i_min_db,
    input  logic signed [dbtc_pkg::DB_W-1:0] i_max_db,
    input  logic                             i_valid,
    input  logic signed [dbtc_pkg::DB_W-1:0] i_db,
    output logic                             o_ready,
    output logic                             o_valid,
    output logic [dbtc_pkg::T_W-1:0]         o_t,
    input  logic                             i_ready
);

    localparam int NSTG = 1 + dbtc_pkg::T_DIV_STAGES;

    logic [NSTG-1:0]   r_v;
    logic [NSTG:0]     adv;
    dbtc_pkg::t_tdiv   r_stg [NSTG];
    dbtc_pkg::t_tdiv   n_stg [NSTG];

    logic signed [dbtc_pkg::DB_W:0] span;
    logic signed [dbtc_pkg::DB_W:0] off;

    // One shift-subtract step of the level divider
    function automatic dbtc_pkg::t_tdiv tdiv_step(input dbtc_pkg::t_tdiv x);
        dbtc_pkg::t_tdiv           y;
        logic [dbtc_pkg::Q_W:0]    r2;
        y  = x;
        r2 = {x.rem, 1'b0};
        if (r2 >= {1'b0, x.div}) begin
            y.rem = dbtc_pkg::Q_W'(r2 - {1'b0, x.div});
            y.q   = {x.q[dbtc_pkg::Q_W-2:0], 1'b1};
        end else begin
            y.rem = r2[dbtc_pkg::Q_W-1:0];
            y.q   = {x.q[dbtc_pkg::Q_W-2:0], 1'b0};
        end
        return y;
    endfunction

    // Offset from the floor and span of the window
    assign span = {i_max_db[dbtc_pkg::DB_W-1], i_max_db} - {i_min_db[dbtc_pkg::DB_W-1], i_min_db};
    assign off  = {i_db[dbtc_pkg::DB_W-1], i_db} - {i_min_db[dbtc_pkg::DB_W-1], i_min_db};

    // Clamp flags; an empty or inverted window lands on the floor color
    always_comb begin
        n_stg[0].zero = (span <= 0) || (off <= 0);
        n_stg[0].one  = (off >= span);
        n_stg[0].rem  = off[dbtc_pkg::Q_W-1:0];
        n_stg[0].div  = span[dbtc_pkg::Q_W-1:0];
        n_stg[0].q    = '0;
    end

    // Advance a stage when it is empty or the next one advances
    assign adv[NSTG] = i_ready;

    genvar k;
    generate
        for (k = 0; k < NSTG; k++) begin : g_stg
            assign adv[k] = !r_v[k] || adv[k+1];

            if (k > 0) begin : g_div
                always_comb begin
                    n_stg[k] = r_stg[k-1];
                    for (int b = 0; b < dbtc_pkg::DIV_STEP; b++) begin
                        n_stg[k] = tdiv_step(n_stg[k]);
                    end
                end

                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) begin
                        r_v[k] <= 1'b0;
                    end else if (adv[k]) begin
                        r_v[k] <= r_v[k-1];
                    end
                end
            end else begin : g_front
                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) begin
                        r_v[k] <= 1'b0;
                    end else if (adv[k]) begin
                        r_v[k] <= i_valid;
                    end
                end
            end

            // Hold the word while the stage is stalled
            always_ff @(posedge i_clk) begin
                if (adv[k]) begin
                    r_stg[k] <= n_stg[k];
                end
            end
        end
    endgenerate

    assign o_ready = adv[0];
    assign o_valid = r_v[NSTG-1];

    // Apply the clamps to the finished quotient
    always_comb begin
        if (r_stg[NSTG-1].zero) begin
            o_t = '0;
        end else if (r_stg[NSTG-1].one) begin
            o_t = dbtc_pkg::T_ONE;
        end else begin
            o_t = {1'b0, r_stg[NSTG-1].q};
        end
    end

`ifndef SYNTHESIS
    // The divider remainder must stay below the span
    a_rem_below_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NSTG-1] && !r_stg[NSTG-1].zero && !r_stg[NSTG-1].one)
            |-> (r_stg[NSTG-1].rem < r_stg[NSTG-1].div))
        else $error("level divider remainder not below span");
`endif

endmodule

### rtl/core/dbtc_seg.sv
// Segment lookup and blend numerators, two pipeline stages.
`timescale 1ns / 1ps

module dbtc_seg (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [dbtc_pkg::T_W-1:0] i_t,
    output logic                     o_ready,
    output logic                     o_valid,
    output dbtc_pkg::t_blend         o_blend,
    input  logic                     i_ready
);

    logic              r_v0;
    logic              r_v1;
    logic              adv0;
    logic              adv1;
    dbtc_pkg::t_segd   r_sd;
    dbtc_pkg::t_segd   n_sd;
    dbtc_pkg::t_blend  r_bl;
    dbtc_pkg::t_blend  n_bl;

    // Pick the first segment whose upper stop is not below the level
    always_comb begin
        logic [dbtc_pkg::SEG_W-1:0] seg;
        seg = dbtc_pkg::SEG_W'(dbtc_pkg::NSEG - 1);
        for (int i = dbtc_pkg::NSEG - 1; i >= 0; i--) begin
            if (i_t <= dbtc_pkg::stop_pos(dbtc_pkg::SEG_W'(i + 1))) begin
                seg = dbtc_pkg::SEG_W'(i);
            end
        end
        n_sd.seg = seg;
        n_sd.d   = dbtc_pkg::D_W'(i_t - dbtc_pkg::stop_pos(seg));
    end

    // Weighted sum of the two stop colors for each channel
    always_comb begin
        dbtc_pkg::t_rgb             ca;
        dbtc_pkg::t_rgb             cb;
        logic [dbtc_pkg::D_W-1:0]   len;
        len = dbtc_pkg::seg_len(r_sd.seg);
        ca  = dbtc_pkg::stop_rgb(r_sd.seg);
        cb  = dbtc_pkg::stop_rgb(r_sd.seg + dbtc_pkg::SEG_W'(1));
        for (int c = 0; c < dbtc_pkg::NCH; c++) begin
            n_bl.num[c] = dbtc_pkg::NUM_W'(ca[c]) * dbtc_pkg::NUM_W'(len - r_sd.d)
                        + dbtc_pkg::NUM_W'(cb[c]) * dbtc_pkg::NUM_W'(r_sd.d);
        end
        n_bl.len = len;
    end

    // Stage handshake
    assign adv1 = !r_v1 || i_ready;
    assign adv0 = !r_v0 || adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            if (adv0) begin
                r_v0 <= i_valid;
            end
            if (adv1) begin
                r_v1 <= r_v0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv0) begin
            r_sd <= n_sd;
        end
        if (adv1) begin
            r_bl <= n_bl;
        end
    end

    assign o_ready = adv0;
    assign o_valid = r_v1;
    assign o_blend = r_bl;

`ifndef SYNTHESIS
    // The offset never runs past the end of its segment
    a_offset_in_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v0 |-> (r_sd.d <= dbtc_pkg::seg_len(r_sd.seg)))
        else $error("segment offset beyond segment length");
`endif

endmodule

### rtl/core/dbtc_cdiv.sv
// Color divider: three parallel lanes, two quotient bits per stage.
`timescale 1ns / 1ps

module dbtc_cdiv (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  dbtc_pkg::t_blend i_blend,
    output logic             o_ready,
    output logic             o_valid,
    output dbtc_pkg::t_rgb   o_rgb,
    input  logic             i_ready
);

    localparam int NSTG = dbtc_pkg::C_DIV_STAGES;

    logic [NSTG-1:0]  r_v;
    logic [NSTG:0]    adv;
    dbtc_pkg::t_cdiv  r_stg [NSTG];
    dbtc_pkg::t_cdiv  n_stg [NSTG];
    dbtc_pkg::t_cdiv  s_in;
    logic             rem_ok;

    // Resolve one quotient bit in every lane
    function automatic dbtc_pkg::t_cdiv cdiv_step(input dbtc_pkg::t_cdiv x, input int bidx);
        dbtc_pkg::t_cdiv               y;
        logic [dbtc_pkg::NUM_W-1:0]    sub;
        y   = x;
        sub = dbtc_pkg::NUM_W'(x.len) << bidx;
        for (int c = 0; c < dbtc_pkg::NCH; c++) begin
            if (x.rem[c] >= sub) begin
                y.rem[c]     = x.rem[c] - sub;
                y.q[c][bidx] = 1'b1;
            end
        end
        return y;
    endfunction

    // Load the numerators; quotient bits fill in stage by stage
    always_comb begin
        s_in.rem = i_blend.num;
        s_in.len = i_blend.len;
        s_in.q   = '0;
    end

    assign adv[NSTG] = i_ready;

    genvar k;
    generate
        for (k = 0; k < NSTG; k++) begin : g_stg
            localparam int B_HI = dbtc_pkg::CH_W - 1 - dbtc_pkg::DIV_STEP * k;

            assign adv[k] = !r_v[k] || adv[k+1];

            if (k > 0) begin : g_mid
                always_comb begin
                    n_stg[k] = r_stg[k-1];
                    for (int b = 0; b < dbtc_pkg::DIV_STEP; b++) begin
                        n_stg[k] = cdiv_step(n_stg[k], B_HI - b);
                    end
                end

                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) begin
                        r_v[k] <= 1'b0;
                    end else if (adv[k]) begin
                        r_v[k] <= r_v[k-1];
                    end
                end
            end else begin : g_first
                always_comb begin
                    n_stg[k] = s_in;
                    for (int b = 0; b < dbtc_pkg::DIV_STEP; b++) begin
                        n_stg[k] = cdiv_step(n_stg[k], B_HI - b);
                    end
                end

                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) begin
                        r_v[k] <= 1'b0;
                    end else if (adv[k]) begin
                        r_v[k] <= i_valid;
                    end
                end
            end

            // Hold the word while the stage is stalled
            always_ff @(posedge i_clk) begin
                if (adv[k]) begin
                    r_stg[k] <= n_stg[k];
                end
            end
        end
    endgenerate

    assign o_ready = adv[0];
    assign o_valid = r_v[NSTG-1];
    assign o_rgb   = r_stg[NSTG-1].q;

    // All lanes end with a remainder below the segment length
    always_comb begin
        rem_ok = 1'b1;
        for (int c = 0; c < dbtc_pkg::NCH; c++) begin
            if (r_stg[NSTG-1].rem[c] >= dbtc_pkg::NUM_W'(r_stg[NSTG-1].len)) begin
                rem_ok = 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_color_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NSTG-1] |-> rem_ok)
        else $error("color divider remainder not below segment length");
`endif

endmodule

### rtl/core/db_to_thermal_color.sv
// Top level of the dB to thermal color mapper: config registers and the stage chain.
//
//  channel   dir  handshake     word
//  i_pix     in   valid/ready   magnitude_db, signed Q8.8
//  o_color   out  valid/ready   red, green, blue, 8 bits each
//  i_cfg     in   valid/ready   index (0 min_db, 1 max_db), data, 16 bits
//
//  One word per cycle sustained while o_color is not held off. Stages in order:
//  offset and clamp, the level divider (two quotient bits per stage), segment
//  lookup, the blend multipliers, then the color divider.
//  Reset loads min_db = -100 dB and max_db = 0 dB; the pipeline needs no clearing.
//  Every stage has its own valid bit and stalls only when full and blocked
//  downstream, so bubbles close up and a stalled result holds in place.
`timescale 1ns / 1ps

module db_to_thermal_color (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dbtc_pix_if.sink    i_pix,
    dbtc_cfg_if.sink    i_cfg,
    dbtc_color_if.source o_color
);

    logic signed [dbtc_pkg::DB_W-1:0] r_min_db;
    logic signed [dbtc_pkg::DB_W-1:0] r_max_db;

    logic                     norm_valid;
    logic                     norm_ready;
    logic [dbtc_pkg::T_W-1:0] norm_t;
    logic                     seg_valid;
    logic                     seg_ready;
    dbtc_pkg::t_blend         seg_blend;
    dbtc_pkg::t_rgb           rgb;

    // Register writes; unknown indexes are dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_db <= dbtc_pkg::MIN_DB_RST;
            r_max_db <= dbtc_pkg::MAX_DB_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                dbtc_pkg::REG_MIN_DB: r_min_db <= i_cfg.data;
                dbtc_pkg::REG_MAX_DB: r_max_db <= i_cfg.data;
                default: ;
            endcase
        end
    end

    dbtc_norm u_norm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_min_db (r_min_db),
        .i_max_db (r_max_db),
        .i_valid  (i_pix.valid),
        .i_db     (i_pix.magnitude_db),
        .o_ready  (i_pix.ready),
        .o_valid  (norm_valid),
        .o_t      (norm_t),
        .i_ready  (norm_ready)
    );

    dbtc_seg u_seg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (norm_valid),
        .i_t     (norm_t),
        .o_ready (norm_ready),
        .o_valid (seg_valid),
        .o_blend (seg_blend),
        .i_ready (seg_ready)
    );

    dbtc_cdiv u_cdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (seg_valid),
        .i_blend (seg_blend),
        .o_ready (seg_ready),
        .o_valid (o_color.valid),
        .o_rgb   (rgb),
        .i_ready (o_color.ready)
    );

    assign o_color.red   = rgb[dbtc_pkg::CH_RED];
    assign o_color.green = rgb[dbtc_pkg::CH_GREEN];
    assign o_color.blue  = rgb[dbtc_pkg::CH_BLUE];

`ifndef SYNTHESIS
    // Input back-pressure only arises from a blocked result at the output
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (o_color.valid && !o_color.ready))
        else $error("input stalled while output is free");
`endif

endmodule

### tb/testbench.sv
// Self-checking testbench for the dB to thermal color mapper.
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 10;
    localparam int PIPE_LATENCY   = 15;
    localparam int HOLD_CYCLES    = 300;
    localparam int LIMIT_CYCLES   = 200000;
    localparam int MAX_PRINTS     = 40;
    localparam int NUM_PHASES     = 11;
    localparam int PRESSURE_PHASE = 4;

    // Indexes outside the register map; writes to them must be dropped
    localparam logic [dbtc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = dbtc_pkg::CFG_IDX_W'(2);
    localparam logic [dbtc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = dbtc_pkg::CFG_IDX_W'(3);

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_RUNS} t_stall_mode;

    typedef struct packed {
        logic [dbtc_pkg::CH_W-1:0] red;
        logic [dbtc_pkg::CH_W-1:0] green;
        logic [dbtc_pkg::CH_W-1:0] blue;
    } t_color;

    // Tracks the floor/ceiling registers and the colors still owed by the block
    class color_tracker;
        logic signed [dbtc_pkg::DB_W-1:0] min_db;
        logic signed [dbtc_pkg::DB_W-1:0] max_db;
        t_color                           owed_colors[$];
        int                               errors;
        int                               stop_at[7];
        int                               stop_red[7];
        int                               stop_green[7];
        int                               stop_blue[7];

        function new();
            min_db     = -16'sd25600;
            max_db     = 16'sd0;
            errors     = 0;
            stop_at    = '{0, 9830, 19661, 32768, 42598, 52429, 65536};
            stop_red   = '{0, 0, 0, 0, 220, 255, 255};
            stop_green = '{0, 0, 180, 220, 220, 80, 255};
            stop_blue  = '{20, 160, 220, 80, 0, 0, 255};
        endfunction

        function int pending();
            return owed_colors.size();
        endfunction

        function void set_reg(logic [dbtc_pkg::CFG_IDX_W-1:0] idx,
                              logic [dbtc_pkg::DB_W-1:0] val);
            case (idx)
                dbtc_pkg::REG_MIN_DB: min_db = val;
                dbtc_pkg::REG_MAX_DB: max_db = val;
                default: ;
            endcase
        endfunction

        // Linear mix of two stop channels, truncated toward zero
        function logic [dbtc_pkg::CH_W-1:0] mix(int a, int b, longint d, longint s);
            longint num;
            num = longint'(a) * (s - d) + longint'(b) * d;
            return dbtc_pkg::CH_W'(num / s);
        endfunction

        function t_color thermal_color(logic signed [dbtc_pkg::DB_W-1:0] db);
            longint span;
            longint off;
            longint level;
            longint s;
            longint d;
            t_color c;
            c.red   = dbtc_pkg::CH_W'(stop_red[0]);
            c.green = dbtc_pkg::CH_W'(stop_green[0]);
            c.blue  = dbtc_pkg::CH_W'(stop_blue[0]);
            // Empty or inverted span: coldest color, no division
            if (max_db <= min_db)
                return c;
            span = longint'(max_db) - longint'(min_db);
            off  = longint'(db) - longint'(min_db);
            if (off <= 0)
                level = 0;
            else if (off >= span)
                level = 65536;
            else
                level = (off <<< 16) / span;
            // First segment holding the level wins, so a boundary uses the lower one
            for (int k = 0; k < 6; k++) begin
                if (level >= stop_at[k] && level <= stop_at[k+1]) begin
                    s = stop_at[k+1] - stop_at[k];
                    d = level - stop_at[k];
                    c.red   = mix(stop_red[k],   stop_red[k+1],   d, s);
                    c.green = mix(stop_green[k], stop_green[k+1], d, s);
                    c.blue  = mix(stop_blue[k],  stop_blue[k+1],  d, s);
                    return c;
                end
            end
            return '1;
        endfunction

        function void note_pixel(logic signed [dbtc_pkg::DB_W-1:0] db);
            owed_colors.push_back(thermal_color(db));
        endfunction

        task report(string what);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("%0t ns: %s", $time, what);
        endtask

        task check_color(logic [dbtc_pkg::CH_W-1:0] r, logic [dbtc_pkg::CH_W-1:0] g,
                         logic [dbtc_pkg::CH_W-1:0] b);
            t_color want;
            if (owed_colors.size() == 0) begin
                report($sformatf("color word %0d/%0d/%0d with no pixel pending", r, g, b));
            end else begin
                want = owed_colors.pop_front();
                if (r !== want.red)
                    report($sformatf("red %0d, expected %0d", r, want.red));
                if (g !== want.green)
                    report($sformatf("green %0d, expected %0d", g, want.green));
                if (b !== want.blue)
                    report($sformatf("blue %0d, expected %0d", b, want.blue));
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    bit          pressure_go = 1'b0;
    logic        holding;
    bit          send_gaps;
    int          burst_left;
    t_stall_mode stall_mode;
    int          corner_db[19];

    color_tracker tracker;

    dbtc_pix_if   pix ();
    dbtc_cfg_if   cfg ();
    dbtc_color_if color ();

    db_to_thermal_color DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .i_cfg   (cfg),
        .o_color (color)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Offer one magnitude word and hold it until taken, then pace the burst
    task send_pixel(input logic signed [dbtc_pkg::DB_W-1:0] db);
        pix.valid        <= 1'b1;
        pix.magnitude_db <= db;
        do @(posedge i_clk); while (!pix.ready);
        tracker.note_pixel(db);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            if (send_gaps) begin
                pix.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    endtask

    // Offer one register word and hold it until taken; the caller drops valid
    task write_reg(input logic [dbtc_pkg::CFG_IDX_W-1:0] idx,
                   input logic [dbtc_pkg::DB_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge i_clk); while (!cfg.ready);
        tracker.set_reg(idx, val);
    endtask

    // Stop offering and wait until every owed color has come back
    task drain_colors();
        pix.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
    endtask

    // Mostly values inside the span and near its ends, some anywhere
    function automatic logic signed [dbtc_pkg::DB_W-1:0] rand_db(int lo, int hi);
        int v;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            v = int'($urandom_range(0, 65535)) - 32768;
        else if (pick == 2)
            v = lo + int'($urandom_range(0, 8)) - 4;
        else if (pick == 3)
            v = hi + int'($urandom_range(0, 8)) - 4;
        else if (hi > lo)
            v = lo + int'($urandom_range(0, hi - lo));
        else
            v = int'($urandom_range(0, 65535)) - 32768;
        if (v < -32768)
            v = -32768;
        if (v > 32767)
            v = 32767;
        return v[dbtc_pkg::DB_W-1:0];
    endfunction

    // Receiver: check accepted colors, then pick the next ready level
    initial begin
        int run_left;
        bit run_ready;
        run_left  = 0;
        run_ready = 1'b1;
        color.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (color.valid && color.ready)
                tracker.check_color(color.red, color.green, color.blue);
            if (!i_rst_n || holding) begin
                color.ready <= 1'b0;
            end else begin
                case (stall_mode)
                    STALL_RANDOM: color.ready <= ($urandom_range(0, 3) != 0);
                    STALL_RUNS: begin
                        if (run_left == 0) begin
                            run_ready = !run_ready;
                            run_left  = run_ready ? $urandom_range(1, 12)
                                                  : $urandom_range(1, 8);
                        end else begin
                            run_left--;
                        end
                        color.ready <= run_ready;
                    end
                    default: color.ready <= 1'b1;
                endcase
            end
        end
    end

    // Long receiver hold-off so the pipeline fills and backs up the input
    initial begin
        holding <= 1'b0;
        wait (pressure_go);
        @(posedge i_clk);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        holding <= 1'b0;
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int lo;
        int hi;
        int n_items;
        int swap;
        tracker          = new();
        i_rst_n          <= 1'b0;
        pix.valid        <= 1'b0;
        pix.magnitude_db <= '0;
        cfg.valid        <= 1'b0;
        cfg.index        <= '0;
        cfg.data         <= '0;
        stall_mode       <= STALL_NONE;
        send_gaps        = 1'b0;
        burst_left       = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Field extremes, floor, ceiling and stop boundaries at reset settings
        corner_db = '{-32768, 32767, -25600, -25601, -25599, 0, -1, 1,
                      -21760, -21761, -21759, -17920, -12800, -12801,
                      -8960, -8959, -5120, -5121, -128};
        foreach (corner_db[k])
            send_pixel(corner_db[k][dbtc_pkg::DB_W-1:0]);
        drain_colors();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            n_items = 105;
            case (phase)
                0: begin lo = -32768; hi = 32767;  n_items = 100; end
                1: begin lo = -32768; hi = -32767; n_items = 40;  end
                2: begin lo = 5000;   hi = 5000;   n_items = 30;  end
                3: begin lo = 32767;  hi = -32768; n_items = 30;  end
                PRESSURE_PHASE: begin lo = -25600; hi = 0; n_items = 120; end
                default: begin
                    lo = int'($urandom_range(0, 65535)) - 32768;
                    case ($urandom_range(0, 3))
                        0: hi = lo + int'($urandom_range(1, 300));
                        3: hi = int'($urandom_range(0, 65535)) - 32768;
                        default: begin
                            hi = int'($urandom_range(0, 65535)) - 32768;
                            if (hi < lo) begin
                                swap = lo;
                                lo   = hi;
                                hi   = swap;
                            end
                        end
                    endcase
                    if (hi > 32767)
                        hi = 32767;
                end
            endcase

            write_reg(dbtc_pkg::REG_MIN_DB, lo[dbtc_pkg::DB_W-1:0]);
            write_reg(dbtc_pkg::REG_MAX_DB, hi[dbtc_pkg::DB_W-1:0]);
            // Writes to unmapped indexes must leave the registers alone
            if (phase == 2) begin
                write_reg(REG_SPARE_LO, 16'h7FFF);
                write_reg(REG_SPARE_HI, 16'h8000);
            end
            cfg.valid <= 1'b0;

            send_gaps  = (phase % 3 != 0) && (phase != PRESSURE_PHASE);
            stall_mode <= t_stall_mode'(phase % 3);
            if (phase == PRESSURE_PHASE)
                pressure_go <= 1'b1;

            repeat (n_items)
                send_pixel(rand_db(lo, hi));
            drain_colors();
        end

        // Catch any stray color word after the last one owed
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);
        if (tracker.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### db_to_thermal_color.f
rtl/core/dbtc_pkg.sv
rtl/core/dbtc_ifs.sv
rtl/core/dbtc_norm.sv
rtl/core/dbtc_seg.sv
rtl/core/dbtc_cdiv.sv
rtl/core/db_to_thermal_color.sv
tb/testbench.sv
